// ----- rtl/mpc_pkg.sv -----
// Shared widths, constants and controller/datapath interface types for the covariance block.
package mpc_pkg;

  localparam int MAX_POINTS = 4096;

  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 29;                  // sum of a, sum of b
  localparam int PSUM_W     = 44;                  // sum of a*b
  localparam int CNT_W      = 13;                  // point count
  localparam int COV_W      = 40;
  localparam int FRAC_W     = 8;

  localparam int PROD_W     = 2 * SAMPLE_W;        // a*b
  localparam int SPLIT_W    = 22;                  // low slice of sum of a*b
  localparam int HI_W       = PSUM_W - SPLIT_W;    // high slice, signed
  localparam int PLO_W      = CNT_W + SPLIT_W;
  localparam int PHI_W      = CNT_W + 1 + HI_W;
  localparam int AB_W       = 2 * SUM_W;
  localparam int DEN_W      = 2 * CNT_W;           // n*n
  localparam int NUM_W      = 60;                  // n*Sab - Sa*Sb with headroom
  localparam int DVD_W      = NUM_W + FRAC_W;      // dividend = |num| << 8
  localparam int STEP_W     = $clog2(DVD_W);

  typedef struct packed {
    logic take;   // register an accepted beat into the accumulate stage
    logic mul;    // form partial products and n*n, clear the sums
    logic num;    // combine the partial products into the numerator
    logic load;   // load the divider with the numerator magnitude
    logic step;   // one restoring-division step
    logic out;    // load the result register
  } ctl_cmd_t;

  typedef struct packed {
    logic beat_last;  // last_point flag of the beat on the input
    logic div_done;   // current step is the final one
  } ctl_sts_t;

endpackage

// ----- rtl/mpc_ctrl.sv -----
// Sequencer: accumulate beats, then run the numerator, the divider and the result load.
module mpc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  mpc_pkg::ctl_sts_t sts,
  output mpc_pkg::ctl_cmd_t cmd
);
  import mpc_pkg::*;

  typedef enum logic [2:0] {
    S_ACC,
    S_ADD,
    S_MUL,
    S_NUM,
    S_LOAD,
    S_DIV,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_vld_r, out_vld_nxt;
  logic   slot_free;

  assign slot_free = !out_vld_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_ACC: begin
        cmd.take = in_valid;
        if (in_valid && sts.beat_last) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_NUM;
      end
      S_NUM: begin
        cmd.num   = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the result register is free
        if (slot_free) begin
          cmd.out   = 1'b1;
          state_nxt = S_ACC;
        end
      end
      default: begin
        state_nxt = S_ACC;
      end
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
    if (cmd.out) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_ACC;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign in_stall  = (state_r != S_ACC);
  assign out_valid = out_vld_r;

endmodule

// ----- rtl/mpc_datapath.sv -----
// Accumulators, product stage, restoring divider and result register.
module mpc_datapath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic                                   cfg_wr_data,
  input  logic signed [mpc_pkg::SAMPLE_W-1:0]    in_sample_a,
  input  logic signed [mpc_pkg::SAMPLE_W-1:0]    in_sample_b,
  input  logic                                   in_point_selected,
  input  logic                                   in_last_point,
  input  mpc_pkg::ctl_cmd_t                      cmd,
  output mpc_pkg::ctl_sts_t                      sts,
  output logic signed [mpc_pkg::COV_W-1:0]       out_covariance,
  output logic        [mpc_pkg::CNT_W-1:0]       out_points_used,
  output logic                                   out_empty_set
);
  import mpc_pkg::*;

  logic use_mask_r;

  // accumulate stage
  logic                       st_vld_r;
  logic                       st_use_r;
  logic signed [SAMPLE_W-1:0] st_a_r, st_b_r;
  logic signed [PROD_W-1:0]   st_prod_r;

  logic signed [SUM_W-1:0]    sa_r, sb_r;
  logic signed [PSUM_W-1:0]   sab_r;
  logic        [CNT_W-1:0]    cnt_r;

  // finalize
  logic        [PLO_W-1:0]    p_lo_r;
  logic signed [PHI_W-1:0]    p_hi_r;
  logic signed [AB_W-1:0]     ab_r;
  logic        [DEN_W-1:0]    d_r;
  logic        [CNT_W-1:0]    n_hold_r;
  logic signed [NUM_W-1:0]    num_r, num_nxt;
  logic                       neg_r;
  logic        [NUM_W-1:0]    mag;

  logic        [DVD_W-1:0]    dvd_r;
  logic        [DEN_W-1:0]    rem_r;
  logic        [STEP_W-1:0]   step_r;
  logic        [DEN_W:0]      rem_sh;
  logic                       ge;
  logic        [DEN_W:0]      rem_sub;

  logic        [COV_W-1:0]    q_lo;
  logic signed [COV_W-1:0]    cov_r;
  logic        [CNT_W-1:0]    used_r;
  logic                       empty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_mask_r <= 1'b0;
    end else if (cfg_wr_en) begin
      use_mask_r <= cfg_wr_data;
    end
  end

  // register the beat with its product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r <= 1'b0;
    end else begin
      st_vld_r <= cmd.take;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      st_use_r  <= !use_mask_r || in_point_selected;
      st_a_r    <= in_sample_a;
      st_b_r    <= in_sample_b;
      st_prod_r <= in_sample_a * in_sample_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_r  <= '0;
      sb_r  <= '0;
      sab_r <= '0;
      cnt_r <= '0;
    end else if (cmd.mul) begin
      sa_r  <= '0;
      sb_r  <= '0;
      sab_r <= '0;
      cnt_r <= '0;
    end else if (st_vld_r && st_use_r && (cnt_r < CNT_W'(MAX_POINTS))) begin
      sa_r  <= sa_r + SUM_W'(st_a_r);
      sb_r  <= sb_r + SUM_W'(st_b_r);
      sab_r <= sab_r + PSUM_W'(st_prod_r);
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // n*Sab in two slices, Sa*Sb and n*n
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p_lo_r   <= cnt_r * sab_r[SPLIT_W-1:0];
      p_hi_r   <= $signed({1'b0, cnt_r}) * $signed(sab_r[PSUM_W-1:SPLIT_W]);
      ab_r     <= sa_r * sb_r;
      d_r      <= cnt_r * cnt_r;
      n_hold_r <= cnt_r;
    end
  end

  assign num_nxt = (NUM_W'(p_hi_r) <<< SPLIT_W) + $signed(NUM_W'(p_lo_r)) - NUM_W'(ab_r);

  always_ff @(posedge clk) begin
    if (cmd.num) begin
      num_r <= num_nxt;
    end
  end

  assign mag = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);

  // restoring divider, one quotient bit per step
  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign ge      = (rem_sh >= {1'b0, d_r});
  assign rem_sub = rem_sh - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dvd_r  <= {mag, {FRAC_W{1'b0}}};
      rem_r  <= '0;
      step_r <= STEP_W'(DVD_W - 1);
      neg_r  <= num_r[NUM_W-1];
    end else if (cmd.step) begin
      dvd_r  <= {dvd_r[DVD_W-2:0], ge};
      rem_r  <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      step_r <= step_r - 1'b1;
    end
  end

  assign sts.div_done  = (step_r == '0);
  assign sts.beat_last = in_last_point;

  assign q_lo = dvd_r[COV_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.out) begin
      used_r  <= n_hold_r;
      empty_r <= (n_hold_r == '0);
      if (n_hold_r == '0) begin
        cov_r <= '0;
      end else begin
        cov_r <= neg_r ? $signed(-q_lo) : $signed(q_lo);
      end
    end
  end

  assign out_covariance  = cov_r;
  assign out_points_used = used_r;
  assign out_empty_set   = empty_r;

endmodule

// ----- rtl/masked_pair_covariance.sv -----
// Top level of the masked pair covariance block: controller plus datapath.
// Accepts one sample pair per cycle while accumulating; each accepted beat
// is registered with its product, and its a, b and a*b are added in the
// following cycle. On the beat marked last_point the input stalls while the
// block adds the last beat, forms the products n*Sab, Sa*Sb and n*n, forms
// the numerator, loads the divider, runs 68 steps of a one-bit-per-cycle
// restoring divider that yields (n*Sab - Sa*Sb)*256/n^2 truncated toward
// zero, and loads the output register. If an earlier result is still stalled
// in the output register, the new result holds in the divider and the input
// stays stalled until that register frees up; once loaded, input resumes
// while the result waits to be taken. use_mask selects whether only beats
// with point_selected count; write it while the block is idle. The count
// saturates at 4096 points per field pair.
module masked_pair_covariance (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [mpc_pkg::SAMPLE_W-1:0] in_sample_a,
  input  logic signed [mpc_pkg::SAMPLE_W-1:0] in_sample_b,
  input  logic                                in_point_selected,
  input  logic                                in_last_point,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mpc_pkg::COV_W-1:0]    out_covariance,
  output logic        [mpc_pkg::CNT_W-1:0]    out_points_used,
  output logic                                out_empty_set
);
  import mpc_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  mpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mpc_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_sample_a       (in_sample_a),
    .in_sample_b       (in_sample_b),
    .in_point_selected (in_point_selected),
    .in_last_point     (in_last_point),
    .cmd               (cmd),
    .sts               (sts),
    .out_covariance    (out_covariance),
    .out_points_used   (out_points_used),
    .out_empty_set     (out_empty_set)
  );

  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_point) |=> in_stall)
    else $error("input not stalled after last beat");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_set) |-> (out_covariance == '0 && out_points_used == '0))
    else $error("empty result carries data");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_points_used <= CNT_W'(MAX_POINTS)
                   && (out_empty_set == (out_points_used == '0))))
    else $error("point count out of range");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for masked_pair_covariance: scoreboard class plus stimulus tasks.
`timescale 1ns / 1ps

module testbench;
  import mpc_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 120;      // covers the finish after a last beat
  localparam int HOLD_CYCLES  = 600;
  localparam int PHASE_ITEMS  = 100;
  localparam longint LIMIT_NS = 4_000_000;

  typedef struct packed {
    logic signed [COV_W-1:0] cov;
    logic        [CNT_W-1:0] pts;
    logic                    empty;
  } cov_stats_t;

  class cov_scoreboard;
    bit             mask_on;
    longint         sum_a, sum_b, sum_ab;
    int unsigned    count;
    cov_stats_t     expected_stats[$];
    int unsigned    errors, beats, frames, checked;

    function new();
      mask_on = 1'b0;
      clear_sums();
    endfunction

    function void clear_sums();
      sum_a = 0;
      sum_b = 0;
      sum_ab = 0;
      count = 0;
    endfunction

    // (n*Sab - Sa*Sb) / n^2 in Q8, truncated toward zero
    function logic [COV_W-1:0] q8_covariance();
      longint          n, num;
      longint unsigned den, mag, res;
      bit              neg;
      n = count;
      if (n == 0) return '0;
      den = n * n;
      num = n * sum_ab - sum_a * sum_b;
      neg = (num < 0);
      mag = neg ? -num : num;
      res = (mag / den) * 256 + ((mag % den) * 256) / den;
      if (neg) res = -res;
      return res[COV_W-1:0];
    endfunction

    function void note_beat(logic signed [SAMPLE_W-1:0] a, logic signed [SAMPLE_W-1:0] b,
                            logic sel, logic last);
      cov_stats_t s;
      beats++;
      if ((!mask_on || sel) && count < MAX_POINTS) begin
        sum_a  += longint'(a);
        sum_b  += longint'(b);
        sum_ab += longint'(a) * longint'(b);
        count++;
      end
      if (last) begin
        s.cov   = q8_covariance();
        s.pts   = count[CNT_W-1:0];
        s.empty = (count == 0);
        expected_stats.push_back(s);
        frames++;
        clear_sums();
      end
    endfunction

    function void check_result(logic signed [COV_W-1:0] cov, logic [CNT_W-1:0] pts,
                               logic empty);
      cov_stats_t s;
      if (expected_stats.size() == 0) begin
        if (errors < 10)
          $display("unexpected result: covariance %0d points %0d empty %0b", cov, pts, empty);
        errors++;
        return;
      end
      s = expected_stats.pop_front();
      checked++;
      if (cov !== s.cov || pts !== s.pts || empty !== s.empty) begin
        if (errors < 10)
          $display("mismatch on result %0d: covariance exp %0d got %0d, points exp %0d got %0d, empty exp %0b got %0b",
                   checked, s.cov, cov, s.pts, pts, s.empty, empty);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] in_sample_a = '0;
  logic signed [SAMPLE_W-1:0] in_sample_b = '0;
  logic in_point_selected = 1'b0;
  logic in_last_point = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [COV_W-1:0] out_covariance;
  logic [CNT_W-1:0] out_points_used;
  logic out_empty_set;

  cov_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned backpressure_cycles = 0;
  int unsigned mask_writes = 0;

  masked_pair_covariance u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample_a       (in_sample_a),
    .in_sample_b       (in_sample_b),
    .in_point_selected (in_point_selected),
    .in_last_point     (in_last_point),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_covariance    (out_covariance),
    .out_points_used   (out_points_used),
    .out_empty_set     (out_empty_set)
  );

  always #2 clk = ~clk;

  // Result side: check taken beats, then pick the stall for the next edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_covariance, out_points_used, out_empty_set);
    if (rst_n && in_valid && in_stall)
      backpressure_cycles++;
    if (hold_seen != hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_seen = hold_req;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_point(logic signed [SAMPLE_W-1:0] a, logic signed [SAMPLE_W-1:0] b,
                            logic sel, logic last);
    in_valid          <= 1'b1;
    in_sample_a       <= a;
    in_sample_b       <= b;
    in_point_selected <= sel;
    in_last_point     <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_beat(a, b, sel, last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Drop valid and let the block finish every pending field pair
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mask(logic value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.mask_on = value;
    mask_writes++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return SAMPLE_W'($signed($urandom_range(0, 15)) - 8);
      default: return r[SAMPLE_W-1:0];
    endcase
  endfunction

  task automatic send_frame(int len, int sel_pct);
    for (int i = 0; i < len; i++)
      send_point(pick_sample(), pick_sample(), $urandom_range(99) < sel_pct, i == len - 1);
  endtask

  task automatic run_phase(logic mask, int idle_pct, int stall_pct, bit with_hold);
    int items;
    int len;
    int sel_pct;
    write_mask(mask);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (with_hold) hold_req++;
    items = 0;
    while (items < PHASE_ITEMS) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      case ($urandom_range(4))
        0:       sel_pct = 0;
        1:       sel_pct = 100;
        2:       sel_pct = 90;
        default: sel_pct = 50;
      endcase
      send_frame(len, sel_pct);
      items += len;
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    #(LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: mask off, so selection bits do not matter
    write_mask(1'b0);
    send_point(16'sh7fff, 16'sh7fff, 1'b0, 1'b0);
    send_point(16'sh8000, 16'sh8000, 1'b1, 1'b1);
    send_point(16'sh7fff, 16'sh8000, 1'b0, 1'b0);
    send_point(16'sh8000, 16'sh7fff, 1'b0, 1'b1);
    send_point(16'sh8000, 16'sh7fff, 1'b0, 1'b1);
    send_point(16'sd5, -16'sd3, 1'b0, 1'b0);
    send_point(-16'sd7, 16'sd11, 1'b1, 1'b0);
    send_point(16'sd1, 16'sd2, 1'b0, 1'b1);

    // Directed: mask on, empty pairs and truncation of a negative fraction
    write_mask(1'b1);
    send_point(16'sd100, 16'sd200, 1'b0, 1'b1);
    send_point(16'sd1, 16'sd2, 1'b0, 1'b0);
    send_point(16'sd3, 16'sd4, 1'b0, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b0, 1'b1);
    send_point(16'sd10, -16'sd10, 1'b1, 1'b0);
    send_point(16'sh7fff, 16'sd0, 1'b0, 1'b0);
    send_point(-16'sd10, 16'sd10, 1'b1, 1'b0);
    send_point(16'sd7, 16'sd3, 1'b0, 1'b1);
    send_point(16'sd0, 16'sd1, 1'b1, 1'b0);
    send_point(16'sd1, 16'sd0, 1'b1, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b1, 1'b1);
    send_point(16'sh8000, 16'sh8000, 1'b1, 1'b0);
    send_point(16'sh7fff, 16'sh8000, 1'b1, 1'b1);

    // Saturate the point count: the tail beyond the limit must be dropped
    write_mask(1'b0);
    send_frame(MAX_POINTS + 8, 50);

    run_phase(1'b1, 0, 0, 1'b0);
    run_phase(1'b0, 60, 0, 1'b0);
    run_phase(1'b1, 0, 60, 1'b1);
    run_phase(1'b0, 26, 26, 1'b0);
    run_phase(1'b1, 0, 0, 1'b1);

    wait_idle();
    sb.errors += sb.expected_stats.size();

    $display("Covered %0d beats in %0d field pairs, %0d results checked, %0d mask writes,",
             sb.beats, sb.frames, sb.checked, mask_writes);
    $display("including a saturated pair and %0d cycles of input back-pressure.",
             backpressure_cycles);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/mpc_pkg.sv
rtl/mpc_ctrl.sv
rtl/mpc_datapath.sv
rtl/masked_pair_covariance.sv
sim/testbench.sv
